[rtl/cstp_pkg.sv]
// ----------------------------------------------------------------------------
// Call stack profiler package
// Shared widths, codes, command and status types, and elaboration helpers.
// ----------------------------------------------------------------------------
package cstp_pkg;

  // Default sizes of the profiled program space and the call stack.
  localparam int LibCountDef    = 16;
  localparam int FuncsPerLibDef = 1024;
  localparam int StackDepthDef  = 64;

  // Fixed field widths of the event and result transactions.
  localparam int OpW     = 3;
  localparam int LibW    = 4;
  localparam int FuncW   = 10;
  localparam int TsW     = 48;
  localparam int StatusW = 2;
  localparam int CountW  = 32;
  localparam int DepthW  = 7;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR_START = 3'd0,
    OP_ENTER       = 3'd1,
    OP_EXIT        = 3'd2,
    OP_BLOCK       = 3'd3,
    OP_READ        = 3'd4
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Source of a write to the counter table.
  typedef enum logic [1:0] {
    TW_NONE   = 2'd0,
    TW_CLEAR  = 2'd1,
    TW_COUNT  = 2'd2,
    TW_CHARGE = 2'd3
  } tbl_wr_e;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECODE = 11'b000_0000_0010,
    S_INIT   = 11'b000_0000_0100,
    S_CLEAR  = 11'b000_0000_1000,
    S_ENT_RD = 11'b000_0001_0000,
    S_ENT_WR = 11'b000_0010_0000,
    S_TOP_RD = 11'b000_0100_0000,
    S_CHG_RD = 11'b000_1000_0000,
    S_CHG_WR = 11'b001_0000_0000,
    S_RES_RD = 11'b010_0000_0000,
    S_RESULT = 11'b100_0000_0000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    in_ready;
    logic    latch;
    logic    red_step;
    logic    clr_step;
    logic    tbl_rd_idx;
    logic    tbl_rd_top;
    tbl_wr_e tbl_wr;
    logic    stk_rd;
    logic    push;
    logic    pop;
    logic    set_mark;
    logic    sp_clear;
    logic    blk_inc;
    logic    status_we;
    status_e status;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic    in_valid;
    opcode_e op;
    logic    red_done;
    logic    clr_last;
    logic    sp_zero;
    logic    sp_one;
    logic    sp_full;
    logic    out_free;
  } sts_t;

  // Address width of a store with n entries, at least one bit.
  function automatic int addr_w(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Number of shifted compare-and-subtract steps that reduce any value up to
  // max_val modulo div; zero when div already exceeds max_val.
  function automatic int reduce_steps(int div, int max_val);
    int n;
    n = 0;
    for (int i = 0; i < 16; i++) begin
      if ((div << i) <= max_val) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

  function automatic int max_int(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

[rtl/cstp_evt_if.sv]
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel that carries one profiling event per transaction.
// ----------------------------------------------------------------------------
interface cstp_evt_if;
  logic                         valid;
  logic                         ready;
  logic [cstp_pkg::OpW-1:0]     opcode;
  logic [cstp_pkg::LibW-1:0]    lib_id;
  logic [cstp_pkg::FuncW-1:0]   func_id;
  logic [cstp_pkg::TsW-1:0]     timestamp;

  modport source (output valid, opcode, lib_id, func_id, timestamp, input ready);
  modport sink   (input valid, opcode, lib_id, func_id, timestamp, output ready);
endinterface

[rtl/cstp_res_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one profiling result per transaction.
// ----------------------------------------------------------------------------
interface cstp_res_if;
  logic                          valid;
  logic                          ready;
  logic [cstp_pkg::StatusW-1:0]  status;
  logic [cstp_pkg::CountW-1:0]   call_count;
  logic [cstp_pkg::TsW-1:0]      self_time;
  logic [cstp_pkg::CountW-1:0]   block_count;
  logic [cstp_pkg::DepthW-1:0]   stack_depth;

  modport source (output valid, status, call_count, self_time, block_count, stack_depth,
                  input ready);
  modport sink   (input valid, status, call_count, self_time, block_count, stack_depth,
                  output ready);
endinterface

[rtl/cstp_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module cstp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [cstp_pkg::addr_w(Depth)-1:0]     waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [cstp_pkg::addr_w(Depth)-1:0]     raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/cstp_ctrl.sv]
// ----------------------------------------------------------------------------
// Profiler controller
// Sequences each event through index reduction, table and stack accesses.
// ----------------------------------------------------------------------------
module cstp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cstp_pkg::sts_t  sts_i,
  output cstp_pkg::cmd_t  cmd_o
);

  cstp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cstp_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      cstp_pkg::S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.latch = 1'b1;
          state_d     = cstp_pkg::S_DECODE;
        end
      end
      cstp_pkg::S_DECODE: begin
        if (!sts_i.red_done) begin
          cmd_o.red_step = 1'b1;
        end else begin
          cmd_o.status_we = 1'b1;
          cmd_o.status    = cstp_pkg::ST_OK;
          unique case (sts_i.op)
            cstp_pkg::OP_CLEAR_START: begin
              cmd_o.sp_clear = 1'b1;
              state_d        = cstp_pkg::S_CLEAR;
            end
            cstp_pkg::OP_ENTER: begin
              if (sts_i.sp_full) begin
                cmd_o.status = cstp_pkg::ST_OVERFLOW;
                state_d      = cstp_pkg::S_RES_RD;
              end else begin
                state_d = cstp_pkg::S_ENT_RD;
              end
            end
            cstp_pkg::OP_EXIT: begin
              if (sts_i.sp_zero) begin
                cmd_o.status = cstp_pkg::ST_UNDERFLOW;
                state_d      = cstp_pkg::S_RES_RD;
              end else begin
                state_d = cstp_pkg::S_TOP_RD;
              end
            end
            cstp_pkg::OP_BLOCK: begin
              cmd_o.blk_inc = 1'b1;
              state_d       = cstp_pkg::S_RES_RD;
            end
            default: begin
              state_d = cstp_pkg::S_RES_RD;
            end
          endcase
        end
      end
      cstp_pkg::S_INIT: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.tbl_wr   = cstp_pkg::TW_CLEAR;
        if (sts_i.clr_last) begin
          state_d = cstp_pkg::S_IDLE;
        end
      end
      cstp_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.tbl_wr   = cstp_pkg::TW_CLEAR;
        if (sts_i.clr_last) begin
          state_d = cstp_pkg::S_ENT_RD;
        end
      end
      cstp_pkg::S_ENT_RD: begin
        cmd_o.tbl_rd_idx = 1'b1;
        cmd_o.stk_rd     = 1'b1;
        state_d          = cstp_pkg::S_ENT_WR;
      end
      cstp_pkg::S_ENT_WR: begin
        cmd_o.tbl_wr = cstp_pkg::TW_COUNT;
        if (sts_i.sp_zero) begin
          // Nothing to charge on an empty stack: push right away.
          cmd_o.push     = 1'b1;
          cmd_o.set_mark = 1'b1;
          state_d        = cstp_pkg::S_RES_RD;
        end else begin
          state_d = cstp_pkg::S_CHG_RD;
        end
      end
      cstp_pkg::S_TOP_RD: begin
        cmd_o.stk_rd = 1'b1;
        state_d      = cstp_pkg::S_CHG_RD;
      end
      cstp_pkg::S_CHG_RD: begin
        cmd_o.tbl_rd_top = 1'b1;
        state_d          = cstp_pkg::S_CHG_WR;
      end
      cstp_pkg::S_CHG_WR: begin
        cmd_o.tbl_wr = cstp_pkg::TW_CHARGE;
        if (sts_i.op == cstp_pkg::OP_EXIT) begin
          cmd_o.pop      = 1'b1;
          cmd_o.set_mark = !sts_i.sp_one;
        end else begin
          cmd_o.push     = 1'b1;
          cmd_o.set_mark = 1'b1;
        end
        state_d = cstp_pkg::S_RES_RD;
      end
      cstp_pkg::S_RES_RD: begin
        cmd_o.tbl_rd_idx = 1'b1;
        state_d          = cstp_pkg::S_RESULT;
      end
      cstp_pkg::S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = cstp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cstp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/cstp_dp.sv]
// ----------------------------------------------------------------------------
// Profiler datapath
// Event registers, index reduction, counter table, call stack and result slot.
// ----------------------------------------------------------------------------
module cstp_dp #(
  parameter int LIB_COUNT     = cstp_pkg::LibCountDef,
  parameter int FUNCS_PER_LIB = cstp_pkg::FuncsPerLibDef,
  parameter int STACK_DEPTH   = cstp_pkg::StackDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  cstp_evt_if.sink            evt_i,
  cstp_res_if.source          res_o,
  input  cstp_pkg::cmd_t      cmd_i,
  output cstp_pkg::sts_t      sts_o
);

  localparam int OpW       = cstp_pkg::OpW;
  localparam int LibW      = cstp_pkg::LibW;
  localparam int FuncW     = cstp_pkg::FuncW;
  localparam int TsW       = cstp_pkg::TsW;
  localparam int StatusW   = cstp_pkg::StatusW;
  localparam int CountW    = cstp_pkg::CountW;
  localparam int DepthW    = cstp_pkg::DepthW;
  localparam int TableSize = LIB_COUNT * FUNCS_PER_LIB;
  localparam int IdxW      = cstp_pkg::addr_w(TableSize);
  localparam int SAddrW    = cstp_pkg::addr_w(STACK_DEPTH);
  localparam int SpW       = $clog2(STACK_DEPTH + 1);
  localparam int TblW      = CountW + TsW;
  localparam int LibSteps  = cstp_pkg::reduce_steps(LIB_COUNT, (1 << LibW) - 1);
  localparam int FuncSteps = cstp_pkg::reduce_steps(FUNCS_PER_LIB, (1 << FuncW) - 1);
  localparam int RedSteps  = cstp_pkg::max_int(LibSteps, FuncSteps);
  localparam int StepW     = cstp_pkg::addr_w(RedSteps + 1);

  // Latched event.
  logic [OpW-1:0]   op_q;
  logic [LibW-1:0]  lib_rem_q, lib_rem_d;
  logic [FuncW-1:0] func_rem_q, func_rem_d;
  logic [TsW-1:0]   ts_q;
  logic [StepW-1:0] steps_q;
  logic [StatusW-1:0] status_q;
  int               shift;

  // Modulo reduction of the ids: one shifted compare-and-subtract per cycle.
  always_comb begin
    lib_rem_d  = lib_rem_q;
    func_rem_d = func_rem_q;
    shift      = int'(steps_q) - 1;
    if (cmd_i.red_step) begin
      if (shift < LibSteps && int'(lib_rem_q) >= (LIB_COUNT << shift)) begin
        lib_rem_d = lib_rem_q - LibW'(LIB_COUNT << shift);
      end
      if (shift < FuncSteps && int'(func_rem_q) >= (FUNCS_PER_LIB << shift)) begin
        func_rem_d = func_rem_q - FuncW'(FUNCS_PER_LIB << shift);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q       <= evt_i.opcode;
      lib_rem_q  <= evt_i.lib_id;
      func_rem_q <= evt_i.func_id;
      ts_q       <= evt_i.timestamp;
      steps_q    <= StepW'(RedSteps);
    end else if (cmd_i.red_step) begin
      lib_rem_q  <= lib_rem_d;
      func_rem_q <= func_rem_d;
      steps_q    <= steps_q - 1'b1;
    end
    if (cmd_i.status_we) begin
      status_q <= cmd_i.status;
    end
  end

  logic [IdxW-1:0] idx;
  assign idx = IdxW'(lib_rem_q) * IdxW'(FUNCS_PER_LIB) + IdxW'(func_rem_q);

  // Control registers.
  logic [SpW-1:0]    sp_q;
  logic [TsW-1:0]    mark_q;
  logic [CountW-1:0] blk_q;
  logic [IdxW-1:0]   clr_q;
  logic              clr_last;

  assign clr_last = (clr_q == IdxW'(TableSize - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= '0;
      mark_q <= '0;
      blk_q  <= '0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.sp_clear) begin
        sp_q <= '0;
      end else if (cmd_i.push) begin
        sp_q <= sp_q + 1'b1;
      end else if (cmd_i.pop) begin
        sp_q <= sp_q - 1'b1;
      end
      if (cmd_i.set_mark) begin
        mark_q <= ts_q;
      end
      if (cmd_i.blk_inc && blk_q != '1) begin
        blk_q <= blk_q + 1'b1;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_last ? '0 : clr_q + 1'b1;
      end
    end
  end

  // Call stack: read at the top entry, written at the free slot.
  logic [SAddrW-1:0] stk_raddr;
  logic [IdxW-1:0]   top;
  logic [SpW-1:0]    sp_dec;

  assign sp_dec    = sp_q - 1'b1;
  assign stk_raddr = (sp_q == '0) ? '0 : sp_dec[SAddrW-1:0];

  cstp_ram #(
    .Width (IdxW),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (sp_q[SAddrW-1:0]),
    .wdata_i (idx),
    .re_i    (cmd_i.stk_rd),
    .raddr_i (stk_raddr),
    .rdata_o (top)
  );

  // Counter table: {call count, self time} per function.
  logic              tbl_we;
  logic [IdxW-1:0]   tbl_waddr;
  logic [TblW-1:0]   tbl_wdata;
  logic [TblW-1:0]   tbl_rdata;
  logic [CountW-1:0] rd_count;
  logic [TsW-1:0]    rd_self;
  logic [TsW-1:0]    elapsed;
  logic [TsW:0]      self_sum;
  logic [TsW-1:0]    self_sat;
  logic [CountW-1:0] count_inc;

  assign rd_count  = tbl_rdata[TblW-1:TsW];
  assign rd_self   = tbl_rdata[TsW-1:0];
  assign elapsed   = ts_q - mark_q;
  assign self_sum  = {1'b0, rd_self} + {1'b0, elapsed};
  assign self_sat  = self_sum[TsW] ? '1 : self_sum[TsW-1:0];
  assign count_inc = (rd_count == '1) ? rd_count : rd_count + 1'b1;
  assign tbl_we    = (cmd_i.tbl_wr != cstp_pkg::TW_NONE);

  always_comb begin
    unique case (cmd_i.tbl_wr)
      cstp_pkg::TW_COUNT: begin
        tbl_waddr = idx;
        tbl_wdata = {count_inc, rd_self};
      end
      cstp_pkg::TW_CHARGE: begin
        tbl_waddr = top;
        tbl_wdata = {rd_count, self_sat};
      end
      default: begin
        tbl_waddr = clr_q;
        tbl_wdata = '0;
      end
    endcase
  end

  cstp_ram #(
    .Width (TblW),
    .Depth (TableSize)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (cmd_i.tbl_rd_idx | cmd_i.tbl_rd_top),
    .raddr_i (cmd_i.tbl_rd_top ? top : idx),
    .rdata_o (tbl_rdata)
  );

  // Result slot.
  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [CountW-1:0]  out_count_q;
  logic [TsW-1:0]     out_self_q;
  logic [CountW-1:0]  out_blk_q;
  logic [DepthW-1:0]  out_depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_count_q  <= rd_count;
      out_self_q   <= rd_self;
      out_blk_q    <= blk_q;
      out_depth_q  <= DepthW'(sp_q);
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_status_q;
  assign res_o.call_count  = out_count_q;
  assign res_o.self_time   = out_self_q;
  assign res_o.block_count = out_blk_q;
  assign res_o.stack_depth = out_depth_q;
  assign evt_i.ready       = cmd_i.in_ready;

  assign sts_o.in_valid = evt_i.valid;
  assign sts_o.op       = cstp_pkg::opcode_e'(op_q);
  assign sts_o.red_done = (steps_q == '0);
  assign sts_o.clr_last = clr_last;
  assign sts_o.sp_zero  = (sp_q == '0);
  assign sts_o.sp_one   = (sp_q == SpW'(1));
  assign sts_o.sp_full  = (sp_q == SpW'(STACK_DEPTH));
  assign sts_o.out_free = !out_valid_q || res_o.ready;

endmodule

[rtl/call_stack_exclusive_time_profiler.sv]
// ----------------------------------------------------------------------------
// Call stack exclusive time profiler
// Function entry/exit profiler with per-function call counts and self time.
// ----------------------------------------------------------------------------
// Each event transaction returns exactly one result transaction. Events are
// handled one at a time: the block takes a new event only once the previous
// one has moved its result into the output register, and that result may
// wait there while the next event is already being processed. A read, a
// basic block and a rejected enter or exit go from decode straight to the
// result read; an enter on an empty stack adds a count update, an enter on
// a non-empty stack adds a count update and a charge, and an exit adds a
// stack read and a charge. The counter table has a single read port, whose
// registered read sits on every read-modify-write. When LIB_COUNT or
// FUNCS_PER_LIB is smaller than the id range, the ids are reduced modulo
// those sizes one shifted subtract per cycle. After reset, and for every
// clear-and-start event, the table is cleared one entry per cycle, all
// LIB_COUNT * FUNCS_PER_LIB entries (16384 at the default sizes), during
// which no event is taken.
// ----------------------------------------------------------------------------
//
// The design splits into a controller state machine that sequences the
// accesses of each event and a datapath that owns the storage. The counter
// table holds the call count and the accumulated self time of every
// function side by side in one RAM word, so a charge or a count update is a
// single read followed by a single write. The call stack is a small RAM of
// table indexes; only the top entry is ever read.
//
// On an enter, the called function's count is incremented first; then, if
// the stack was not empty, the ticks since the last mark are charged to the
// function on top, and in either case the new function is pushed. On an
// exit, the top is charged and popped. A recursive call charges and counts
// the same entry, which works because the two updates are separate
// read-write pairs. All counters saturate, and elapsed time is taken modulo
// 2^48 so that a wrap of the timestamp counter is harmless.
module call_stack_exclusive_time_profiler #(
  parameter int LIB_COUNT     = cstp_pkg::LibCountDef,
  parameter int FUNCS_PER_LIB = cstp_pkg::FuncsPerLibDef,
  parameter int STACK_DEPTH   = cstp_pkg::StackDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cstp_evt_if.sink    evt_i,
  cstp_res_if.source  res_o
);

  cstp_pkg::cmd_t cmd;
  cstp_pkg::sts_t sts;

  // Sequencer: steps each event through its table and stack accesses.
  cstp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Storage, arithmetic and the result register.
  cstp_dp #(
    .LIB_COUNT     (LIB_COUNT),
    .FUNCS_PER_LIB (FUNCS_PER_LIB),
    .STACK_DEPTH   (STACK_DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_i),
    .res_o  (res_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
